@@ hw/rtl/wav_header_stream_parser_unit_assert.svh @@
// ----------------------------------------------------------------------------
// WAV header parser assertion macros
// Concurrent assertion wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef WAV_HEADER_STREAM_PARSER_UNIT_ASSERT_SVH
`define WAV_HEADER_STREAM_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define WHSP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle that implies a condition in the next cycle.
`define WHSP_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`else

`define WHSP_ASSERT(label, clk, rst_n, prop, msg)
`define WHSP_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg)

`endif

`endif

@@ hw/rtl/wavhp_pkg.sv @@
// ----------------------------------------------------------------------------
// WAV header parser package
// Shared result type, status and format codes, chunk tags and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package wavhp_pkg;

    // Status codes reported with every byte.
    typedef enum logic [2:0] {
        ST_NEED_MORE    = 3'd0,
        ST_HEADER_READY = 3'd1,
        ST_NO_RIFF      = 3'd2,
        ST_NO_WAVE      = 3'd3,
        ST_FAILED       = 3'd4
    } status_t;

    // Format classes derived from the format tag.
    typedef enum logic [2:0] {
        FC_UNKNOWN = 3'd0,
        FC_PCM     = 3'd1,
        FC_FLOAT   = 3'd2,
        FC_ALAW    = 3'd3,
        FC_MULAW   = 3'd4
    } format_class_t;

    // Kind of the chunk whose size field is being read.
    typedef enum logic [1:0] {
        KIND_UNKNOWN = 2'd0,
        KIND_FMT     = 2'd1,
        KIND_DATA    = 2'd2
    } chunk_kind_t;

    // Little-endian four-character tags.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Format tags.
    localparam logic [15:0] FORMAT_PCM        = 16'h0001;
    localparam logic [15:0] FORMAT_FLOAT      = 16'h0003;
    localparam logic [15:0] FORMAT_ALAW       = 16'h0006;
    localparam logic [15:0] FORMAT_MULAW      = 16'h0007;
    localparam logic [15:0] FORMAT_EXTENSIBLE = 16'hFFFE;

    // fmt chunk lengths.
    localparam logic [31:0] FMT_PLAIN_LEN    = 32'd16;
    localparam logic [31:0] FMT_EXT_MIN_LEN  = 32'd40;
    localparam logic [31:0] FMT_EXT_USED_LEN = 32'd26;
    localparam logic [31:0] EXT_GAP_LEN      = 32'd8;

    // Field byte counts.
    localparam logic [2:0] LEN_WORD = 3'd4;
    localparam logic [2:0] LEN_HALF = 3'd2;

    // One result transaction.
    typedef struct packed {
        status_t       status;
        logic          consumed;
        format_class_t format_class;
        logic [15:0]   raw_format_tag;
        logic [15:0]   channel_count;
        logic [31:0]   sample_rate_hz;
        logic [15:0]   sample_bits;
        logic [31:0]   data_length;
    } result_t;

    // Maps a format tag onto its class.
    function automatic format_class_t class_of(input logic [15:0] tag);
        format_class_t fc;
        unique case (tag)
            FORMAT_PCM:   fc = FC_PCM;
            FORMAT_FLOAT: fc = FC_FLOAT;
            FORMAT_ALAW:  fc = FC_ALAW;
            FORMAT_MULAW: fc = FC_MULAW;
            default:      fc = FC_UNKNOWN;
        endcase
        return fc;
    endfunction

    // Rounds a chunk length up to even, wrapping at 32 bits.
    function automatic logic [31:0] even_up(input logic [31:0] n);
        logic [31:0] sum;
        sum = n + 32'd1;
        return {sum[31:1], 1'b0};
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/wav_header_stream_parser_unit.sv @@
// ----------------------------------------------------------------------------
// WAV header stream parser
// Walks a RIFF/WAVE header one byte per transaction and reports the
// parsed fmt fields and the data chunk size.
// ----------------------------------------------------------------------------
// The block accepts one file byte per clock cycle and returns exactly one
// result per byte, registered in the output buffer. All parser state is
// updated by a single pass of logic in the accept cycle; a two-entry output
// buffer lets the input keep accepting while a result waits downstream, so a
// stalled output holds the input off only once both entries are full. Assert
// start_of_file with the first byte of a file to clear all parser state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wav_header_stream_parser_unit_assert.svh"

module wav_header_stream_parser_unit
    import wavhp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        start_of_file,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic             consumed,
    output logic [2:0]       format_class,
    output logic [15:0]      raw_format_tag,
    output logic [15:0]      channel_count,
    output logic [31:0]      sample_rate_hz,
    output logic [15:0]      sample_bits,
    output logic [31:0]      data_length
);

    typedef enum logic [3:0] {
        PH_RIFF_TAG   = 4'd0,
        PH_RIFF_SIZE  = 4'd1,
        PH_WAVE_TAG   = 4'd2,
        PH_CHUNK_TAG  = 4'd3,
        PH_CHUNK_SIZE = 4'd4,
        PH_FMT_FORMAT = 4'd5,
        PH_FMT_CHAN   = 4'd6,
        PH_FMT_RATE   = 4'd7,
        PH_FMT_BRATE  = 4'd8,
        PH_FMT_ALIGN  = 4'd9,
        PH_FMT_BITS   = 4'd10,
        PH_FMT_SUB    = 4'd11,
        PH_IN_DATA    = 4'd12,
        PH_FAILED     = 4'd13
    } phase_t;

    // Parser state.
    phase_t      phase_reg,     phase_next,     cur_phase;
    chunk_kind_t kind_reg,      kind_next,      cur_kind;
    logic [31:0] field_reg,     field_next,     cur_field;
    logic [2:0]  held_reg,      held_next,      cur_held;
    logic [2:0]  needed_reg,    needed_next,    cur_needed;
    logic [31:0] skip_reg,      skip_next,      cur_skip;
    logic [31:0] chunk_reg,     chunk_next,     cur_chunk;
    logic [31:0] rate_reg,      rate_next,      cur_rate;
    logic [15:0] chan_reg,      chan_next,      cur_chan;
    logic [15:0] bits_reg,      bits_next,      cur_bits;
    logic [15:0] format_reg,    format_next,    cur_format;
    logic [31:0] data_size_reg, data_size_next, cur_data_size;

    logic        accept;
    logic        buf_ready;
    status_t     step_status;
    logic        step_taken;
    logic [31:0] word;
    logic [2:0]  held_inc;
    result_t     step_result;
    result_t     out_result;

    assign in_ready = buf_ready;
    assign accept   = in_valid && buf_ready;

    // Start of file clears the state seen by this byte.
    always_comb
    begin
        cur_phase     = start_of_file ? PH_RIFF_TAG  : phase_reg;
        cur_kind      = start_of_file ? KIND_UNKNOWN : kind_reg;
        cur_field     = start_of_file ? 32'd0        : field_reg;
        cur_held      = start_of_file ? 3'd0         : held_reg;
        cur_needed    = start_of_file ? LEN_WORD     : needed_reg;
        cur_skip      = start_of_file ? 32'd0        : skip_reg;
        cur_chunk     = start_of_file ? 32'd0        : chunk_reg;
        cur_rate      = start_of_file ? 32'd0        : rate_reg;
        cur_chan      = start_of_file ? 16'd0        : chan_reg;
        cur_bits      = start_of_file ? 16'd0        : bits_reg;
        cur_format    = start_of_file ? 16'd0        : format_reg;
        cur_data_size = start_of_file ? 32'd0        : data_size_reg;
    end

    // Byte handling: skipping, field assembly and the action on a full field.
    always_comb
    begin
        phase_next     = cur_phase;
        kind_next      = cur_kind;
        field_next     = cur_field;
        held_next      = cur_held;
        needed_next    = cur_needed;
        skip_next      = cur_skip;
        chunk_next     = cur_chunk;
        rate_next      = cur_rate;
        chan_next      = cur_chan;
        bits_next      = cur_bits;
        format_next    = cur_format;
        data_size_next = cur_data_size;
        step_status    = ST_NEED_MORE;
        step_taken     = 1'b0;
        word           = ((cur_held == 3'd0) ? 32'd0 : cur_field)
                       | ({24'd0, data_byte} << {cur_held[1:0], 3'b000});
        held_inc       = cur_held + 3'd1;

        if (cur_phase == PH_IN_DATA)
        begin
            step_status = ST_HEADER_READY;
        end
        else if (cur_phase == PH_FAILED)
        begin
            step_status = ST_FAILED;
        end
        else if (cur_skip != 32'd0)
        begin
            skip_next  = cur_skip - 32'd1;
            step_taken = 1'b1;
        end
        else
        begin
            step_taken = 1'b1;
            field_next = word;
            held_next  = held_inc;
            if (held_inc >= cur_needed)
            begin
                held_next = 3'd0;
                unique case (cur_phase)
                    PH_RIFF_TAG:
                    begin
                        if (word != TAG_RIFF)
                        begin
                            phase_next  = PH_FAILED;
                            step_status = ST_NO_RIFF;
                        end
                        else
                        begin
                            phase_next  = PH_RIFF_SIZE;
                            needed_next = LEN_WORD;
                        end
                    end
                    PH_RIFF_SIZE:
                    begin
                        phase_next  = PH_WAVE_TAG;
                        needed_next = LEN_WORD;
                    end
                    PH_WAVE_TAG:
                    begin
                        if (word != TAG_WAVE)
                        begin
                            phase_next  = PH_FAILED;
                            step_status = ST_NO_WAVE;
                        end
                        else
                        begin
                            phase_next  = PH_CHUNK_TAG;
                            needed_next = LEN_WORD;
                        end
                    end
                    PH_CHUNK_TAG:
                    begin
                        if (word == TAG_FMT)
                        begin
                            kind_next = KIND_FMT;
                        end
                        else if (word == TAG_DATA)
                        begin
                            kind_next = KIND_DATA;
                        end
                        else
                        begin
                            kind_next = KIND_UNKNOWN;
                        end
                        phase_next  = PH_CHUNK_SIZE;
                        needed_next = LEN_WORD;
                    end
                    PH_CHUNK_SIZE:
                    begin
                        chunk_next = word;
                        if (cur_kind == KIND_FMT)
                        begin
                            if (word < FMT_PLAIN_LEN)
                            begin
                                phase_next  = PH_FAILED;
                                step_status = ST_FAILED;
                            end
                            else
                            begin
                                phase_next  = PH_FMT_FORMAT;
                                needed_next = LEN_HALF;
                            end
                        end
                        else if (cur_kind == KIND_DATA)
                        begin
                            data_size_next = word;
                            phase_next     = PH_IN_DATA;
                            step_status    = ST_HEADER_READY;
                        end
                        else
                        begin
                            skip_next   = even_up(word);
                            phase_next  = PH_CHUNK_TAG;
                            needed_next = LEN_WORD;
                        end
                    end
                    PH_FMT_FORMAT:
                    begin
                        format_next = word[15:0];
                        phase_next  = PH_FMT_CHAN;
                        needed_next = LEN_HALF;
                    end
                    PH_FMT_CHAN:
                    begin
                        chan_next   = word[15:0];
                        phase_next  = PH_FMT_RATE;
                        needed_next = LEN_WORD;
                    end
                    PH_FMT_RATE:
                    begin
                        rate_next   = word;
                        phase_next  = PH_FMT_BRATE;
                        needed_next = LEN_WORD;
                    end
                    PH_FMT_BRATE:
                    begin
                        phase_next  = PH_FMT_ALIGN;
                        needed_next = LEN_HALF;
                    end
                    PH_FMT_ALIGN:
                    begin
                        phase_next  = PH_FMT_BITS;
                        needed_next = LEN_HALF;
                    end
                    PH_FMT_BITS:
                    begin
                        bits_next = word[15:0];
                        if (cur_format == FORMAT_EXTENSIBLE)
                        begin
                            if (cur_chunk < FMT_EXT_MIN_LEN)
                            begin
                                phase_next  = PH_FAILED;
                                step_status = ST_FAILED;
                            end
                            else
                            begin
                                skip_next   = EXT_GAP_LEN;
                                phase_next  = PH_FMT_SUB;
                                needed_next = LEN_HALF;
                            end
                        end
                        else
                        begin
                            if (cur_chunk > FMT_PLAIN_LEN)
                            begin
                                skip_next = even_up(cur_chunk) - FMT_PLAIN_LEN;
                            end
                            phase_next  = PH_CHUNK_TAG;
                            needed_next = LEN_WORD;
                        end
                    end
                    PH_FMT_SUB:
                    begin
                        format_next = word[15:0];
                        if (cur_chunk > FMT_EXT_USED_LEN)
                        begin
                            skip_next = even_up(cur_chunk) - FMT_EXT_USED_LEN;
                        end
                        phase_next  = PH_CHUNK_TAG;
                        needed_next = LEN_WORD;
                    end
                    default:
                    begin
                        phase_next  = PH_FAILED;
                        step_status = ST_FAILED;
                    end
                endcase
            end
        end
    end

    // Result of this byte, taken from the updated state.
    always_comb
    begin
        step_result.status         = step_status;
        step_result.consumed       = step_taken;
        step_result.format_class   = class_of(format_next);
        step_result.raw_format_tag = format_next;
        step_result.channel_count  = chan_next;
        step_result.sample_rate_hz = rate_next;
        step_result.sample_bits    = bits_next;
        step_result.data_length    = data_size_next;
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_RIFF_TAG;
            kind_reg      <= KIND_UNKNOWN;
            field_reg     <= 32'd0;
            held_reg      <= 3'd0;
            needed_reg    <= LEN_WORD;
            skip_reg      <= 32'd0;
            chunk_reg     <= 32'd0;
            rate_reg      <= 32'd0;
            chan_reg      <= 16'd0;
            bits_reg      <= 16'd0;
            format_reg    <= 16'd0;
            data_size_reg <= 32'd0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            field_reg     <= field_next;
            held_reg      <= held_next;
            needed_reg    <= needed_next;
            skip_reg      <= skip_next;
            chunk_reg     <= chunk_next;
            rate_reg      <= rate_next;
            chan_reg      <= chan_next;
            bits_reg      <= bits_next;
            format_reg    <= format_next;
            data_size_reg <= data_size_next;
        end
    end

    // Result buffer.
    wavhp_out_buffer u_out_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (buf_ready),
        .in_data   (step_result),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_result)
    );

    assign status         = out_result.status;
    assign consumed       = out_result.consumed;
    assign format_class   = out_result.format_class;
    assign raw_format_tag = out_result.raw_format_tag;
    assign channel_count  = out_result.channel_count;
    assign sample_rate_hz = out_result.sample_rate_hz;
    assign sample_bits    = out_result.sample_bits;
    assign data_length    = out_result.data_length;

    // A partly gathered field never reaches its target length.
    `WHSP_ASSERT(a_held_below_needed, clk, rst_n, held_reg < needed_reg,
        "held byte count reached the field length")
    // Skipping happens only between chunks or in the extensible gap.
    `WHSP_ASSERT(a_skip_phase, clk, rst_n,
        skip_reg == 32'd0 || phase_reg == PH_CHUNK_TAG || phase_reg == PH_FMT_SUB,
        "skip count pending in an unexpected phase")
    // The failed phase holds until a new file starts.
    `WHSP_ASSERT_NEXT(a_failed_sticky, clk, rst_n,
        phase_reg == PH_FAILED && !(accept && start_of_file), phase_reg == PH_FAILED,
        "parser left the failed phase without a new file")
    // Once the header is done it stays done until a new file starts.
    `WHSP_ASSERT_NEXT(a_done_sticky, clk, rst_n,
        phase_reg == PH_IN_DATA && !(accept && start_of_file), phase_reg == PH_IN_DATA,
        "parser left the data phase without a new file")

endmodule

`default_nettype wire

@@ hw/rtl/wavhp_out_buffer.sv @@
// ----------------------------------------------------------------------------
// WAV header parser output buffer
// Two-entry output register with a skid stage, so a new result can be
// written while the previous one still waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wav_header_stream_parser_unit_assert.svh"

module wavhp_out_buffer
    import wavhp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire result_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_valid_next;
    logic    skid_valid_next;
    logic    load_out;
    logic    load_skid;
    logic    move_skid;
    logic    push;
    logic    pop;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Steering of a new transaction into the output or the skid register.
    always_comb
    begin
        load_out        = 1'b0;
        load_skid       = 1'b0;
        move_skid       = 1'b0;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                move_skid       = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= in_data;
        end
        else if (move_skid)
        begin
            out_data_reg <= skid_data_reg;
        end
        if (load_skid)
        begin
            skid_data_reg <= in_data;
        end
    end

    // The skid entry is only ever occupied behind a full output register.
    `WHSP_ASSERT(a_skid_behind_out, clk, rst_n, !skid_valid_reg || out_valid_reg,
        "skid entry valid while output register is empty")
    // A transaction written during a stall lands in the skid entry.
    `WHSP_ASSERT_NEXT(a_stall_fills_skid, clk, rst_n,
        push && out_valid_reg && !out_ready, skid_valid_reg,
        "transaction written during a stall was not kept")
    // A drained skid entry refills the output register.
    `WHSP_ASSERT_NEXT(a_skid_drains, clk, rst_n,
        skid_valid_reg && out_ready, out_valid_reg && !skid_valid_reg,
        "skid entry did not move to the output register")

endmodule

`default_nettype wire

@@ test/tb_wav_header_stream_parser_unit.sv @@
// ----------------------------------------------------------------------------
// WAV header stream parser testbench
// Streams WAV files one byte per transaction through the parser. A
// scoreboard runs its own byte-level model of the header walk, including
// tag checks, fmt decoding, chunk skips and the terminal phases. It checks
// every result field against the model. Most files are well formed with
// random content. The rest are truncated, corrupt or random noise. Both
// sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module tb_wav_header_stream_parser_unit;

    import wavhp_pkg::*;

    // Phases of the header walk as the scoreboard tracks them.
    typedef enum logic [3:0] {
        P_RIFF_ID,
        P_RIFF_LEN,
        P_WAVE_ID,
        P_CHUNK_ID,
        P_CHUNK_LEN,
        P_FMT_TAG,
        P_FMT_CHANNELS,
        P_FMT_RATE,
        P_FMT_BYTE_RATE,
        P_FMT_ALIGN,
        P_FMT_BITS,
        P_FMT_SUBTAG,
        P_DATA,
        P_DEAD
    } walk_phase_t;

    // Tracks the parser state and checks each result against the expected one.
    class header_scoreboard;
        walk_phase_t phase;
        chunk_kind_t kind;
        logic [31:0] word;
        logic [2:0]  held;
        logic [2:0]  needed;
        logic [31:0] skip_left;
        logic [31:0] chunk_len;
        logic [31:0] rate;
        logic [15:0] channels;
        logic [15:0] bits;
        logic [15:0] fmt_tag;
        logic [31:0] data_len;
        result_t     expected_results[$];
        int unsigned mismatches;
        int unsigned items_noted;
        int unsigned results_seen;

        function new();
            clear();
            mismatches   = 0;
            items_noted  = 0;
            results_seen = 0;
        endfunction

        function void clear();
            phase     = P_RIFF_ID;
            kind      = KIND_UNKNOWN;
            word      = '0;
            held      = '0;
            needed    = LEN_WORD;
            skip_left = '0;
            chunk_len = '0;
            rate      = '0;
            channels  = '0;
            bits      = '0;
            fmt_tag   = '0;
            data_len  = '0;
        endfunction

        // Rounds a length up to even; the sum wraps at 32 bits.
        function logic [31:0] round_even(logic [31:0] n);
            logic [31:0] sum;
            sum = n + 32'd1;
            return sum & 32'hFFFF_FFFE;
        endfunction

        function format_class_t classify(logic [15:0] t);
            case (t)
                FORMAT_PCM:   return FC_PCM;
                FORMAT_FLOAT: return FC_FLOAT;
                FORMAT_ALAW:  return FC_ALAW;
                FORMAT_MULAW: return FC_MULAW;
                default:      return FC_UNKNOWN;
            endcase
        endfunction

        // Acts on a complete little-endian field and returns the status.
        function status_t close_field();
            status_t st;
            st = ST_NEED_MORE;
            case (phase)
                P_RIFF_ID:
                begin
                    if (word != TAG_RIFF)
                    begin
                        phase = P_DEAD;
                        st = ST_NO_RIFF;
                    end
                    else
                    begin
                        phase = P_RIFF_LEN;
                        needed = LEN_WORD;
                    end
                end
                P_RIFF_LEN:
                begin
                    phase = P_WAVE_ID;
                    needed = LEN_WORD;
                end
                P_WAVE_ID:
                begin
                    if (word != TAG_WAVE)
                    begin
                        phase = P_DEAD;
                        st = ST_NO_WAVE;
                    end
                    else
                    begin
                        phase = P_CHUNK_ID;
                        needed = LEN_WORD;
                    end
                end
                P_CHUNK_ID:
                begin
                    if (word == TAG_FMT)
                        kind = KIND_FMT;
                    else if (word == TAG_DATA)
                        kind = KIND_DATA;
                    else
                        kind = KIND_UNKNOWN;
                    phase = P_CHUNK_LEN;
                    needed = LEN_WORD;
                end
                P_CHUNK_LEN:
                begin
                    chunk_len = word;
                    if (kind == KIND_FMT)
                    begin
                        if (word < FMT_PLAIN_LEN)
                        begin
                            phase = P_DEAD;
                            st = ST_FAILED;
                        end
                        else
                        begin
                            phase = P_FMT_TAG;
                            needed = LEN_HALF;
                        end
                    end
                    else if (kind == KIND_DATA)
                    begin
                        data_len = word;
                        phase = P_DATA;
                        st = ST_HEADER_READY;
                    end
                    else
                    begin
                        skip_left = round_even(word);
                        phase = P_CHUNK_ID;
                        needed = LEN_WORD;
                    end
                end
                P_FMT_TAG:
                begin
                    fmt_tag = word[15:0];
                    phase = P_FMT_CHANNELS;
                    needed = LEN_HALF;
                end
                P_FMT_CHANNELS:
                begin
                    channels = word[15:0];
                    phase = P_FMT_RATE;
                    needed = LEN_WORD;
                end
                P_FMT_RATE:
                begin
                    rate = word;
                    phase = P_FMT_BYTE_RATE;
                    needed = LEN_WORD;
                end
                P_FMT_BYTE_RATE:
                begin
                    phase = P_FMT_ALIGN;
                    needed = LEN_HALF;
                end
                P_FMT_ALIGN:
                begin
                    phase = P_FMT_BITS;
                    needed = LEN_HALF;
                end
                P_FMT_BITS:
                begin
                    bits = word[15:0];
                    if (fmt_tag == FORMAT_EXTENSIBLE)
                    begin
                        if (chunk_len < FMT_EXT_MIN_LEN)
                        begin
                            phase = P_DEAD;
                            st = ST_FAILED;
                        end
                        else
                        begin
                            skip_left = EXT_GAP_LEN;
                            phase = P_FMT_SUBTAG;
                            needed = LEN_HALF;
                        end
                    end
                    else
                    begin
                        if (chunk_len > FMT_PLAIN_LEN)
                            skip_left = round_even(chunk_len) - FMT_PLAIN_LEN;
                        phase = P_CHUNK_ID;
                        needed = LEN_WORD;
                    end
                end
                P_FMT_SUBTAG:
                begin
                    fmt_tag = word[15:0];
                    if (chunk_len > FMT_EXT_USED_LEN)
                        skip_left = round_even(chunk_len) - FMT_EXT_USED_LEN;
                    phase = P_CHUNK_ID;
                    needed = LEN_WORD;
                end
                P_DATA:
                    st = ST_HEADER_READY;
                default:
                begin
                    phase = P_DEAD;
                    st = ST_FAILED;
                end
            endcase
            return st;
        endfunction

        // Notes an accepted byte and queues the result it must produce.
        function void note_byte(logic [7:0] b, logic sof);
            result_t r;
            status_t st;
            logic    took;
            st = ST_NEED_MORE;
            took = 1'b0;
            if (sof)
                clear();
            if (phase == P_DATA)
                st = ST_HEADER_READY;
            else if (phase == P_DEAD)
                st = ST_FAILED;
            else if (skip_left != 0)
            begin
                skip_left = skip_left - 32'd1;
                took = 1'b1;
            end
            else
            begin
                took = 1'b1;
                if (held == 0)
                    word = '0;
                word = word | ({24'd0, b} << {held[1:0], 3'b000});
                held = held + 3'd1;
                if (held >= needed)
                begin
                    st = close_field();
                    held = '0;
                end
            end
            items_noted++;
            r.status         = st;
            r.consumed       = took;
            r.format_class   = classify(fmt_tag);
            r.raw_format_tag = fmt_tag;
            r.channel_count  = channels;
            r.sample_rate_hz = rate;
            r.sample_bits    = bits;
            r.data_length    = data_len;
            expected_results.push_back(r);
        endfunction

        task report_mismatch(string what);
            if (mismatches < 100)
                $display("MISMATCH at result %0d: %s", results_seen, what);
            mismatches++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        endtask

        // Checks one result transaction against the oldest expectation.
        task check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
                report_mismatch("result with no expectation pending");
            else
            begin
                want = expected_results.pop_front();
                compare_field("status", 32'(got.status), 32'(want.status));
                compare_field("consumed", 32'(got.consumed), 32'(want.consumed));
                compare_field("format_class", 32'(got.format_class),
                              32'(want.format_class));
                compare_field("raw_format_tag", 32'(got.raw_format_tag),
                              32'(want.raw_format_tag));
                compare_field("channel_count", 32'(got.channel_count),
                              32'(want.channel_count));
                compare_field("sample_rate_hz", got.sample_rate_hz, want.sample_rate_hz);
                compare_field("sample_bits", 32'(got.sample_bits), 32'(want.sample_bits));
                compare_field("data_length", got.data_length, want.data_length);
            end
            results_seen++;
        endtask

        task report_leftovers();
            if (expected_results.size() != 0)
                report_mismatch($sformatf("%0d expected results never arrived",
                                          expected_results.size()));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        start_of_file = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic        consumed;
    logic [2:0]  format_class;
    logic [15:0] raw_format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_rate_hz;
    logic [15:0] sample_bits;
    logic [31:0] data_length;

    header_scoreboard board = new();
    result_t          observed;
    logic [7:0]       file_bytes[$];
    logic             in_steady = 1'b0;
    logic             out_steady = 1'b0;

    wav_header_stream_parser_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .start_of_file  (start_of_file),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .consumed       (consumed),
        .format_class   (format_class),
        .raw_format_tag (raw_format_tag),
        .channel_count  (channel_count),
        .sample_rate_hz (sample_rate_hz),
        .sample_bits    (sample_bits),
        .data_length    (data_length)
    );

    always #5 clk = ~clk;

    // Watch both channels; inputs are noted before results are checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_byte(data_byte, start_of_file);
            if (out_valid && out_ready)
            begin
                observed.status         = status_t'(status);
                observed.consumed       = consumed;
                observed.format_class   = format_class_t'(format_class);
                observed.raw_format_tag = raw_format_tag;
                observed.channel_count  = channel_count;
                observed.sample_rate_hz = sample_rate_hz;
                observed.sample_bits    = sample_bits;
                observed.data_length    = data_length;
                board.check_result(observed);
            end
        end
    end

    // Result side: a random stall before each transaction.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = out_steady ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Sends one byte after a random gap and waits until it is taken.
    task automatic send_byte(logic [7:0] b, logic sof);
        int gap;
        gap = in_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        start_of_file <= sof;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == 0);
    endtask

    task automatic push_word(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(w[8*i +: 8]);
    endtask

    task automatic push_half(logic [15:0] h);
        file_bytes.push_back(h[7:0]);
        file_bytes.push_back(h[15:8]);
    endtask

    task automatic push_random(int unsigned n);
        repeat (n) file_bytes.push_back(8'($urandom));
    endtask

    function automatic logic [15:0] pick_format_tag();
        case ($urandom_range(0, 6))
            0: return FORMAT_PCM;
            1: return FORMAT_FLOAT;
            2: return FORMAT_ALAW;
            3: return FORMAT_MULAW;
            4, 5: return FORMAT_EXTENSIBLE;
            default: return 16'($urandom);
        endcase
    endfunction

    // An unknown chunk; a length too large to stream ends the file early.
    task automatic add_other_chunk(inout logic cut);
        logic [31:0] len;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            len = $urandom_range(0, 9);
        else if (pick == 7)
            len = 32'hFFFF_FFFF;
        else if (pick == 8)
            len = 32'hFFFF_FFFE;
        else
            len = $urandom;
        push_word($urandom);
        push_word(len);
        if (len < 32'd16)
            push_random((len + 32'd1) & 32'hFFFF_FFFE);
        else if (len != 32'hFFFF_FFFF)
        begin
            push_random($urandom_range(0, 6));
            cut = 1'b1;
        end
    endtask

    // A fmt chunk in plain or extensible form, sometimes too short.
    task automatic add_fmt_chunk(inout logic cut);
        logic [31:0] len;
        logic [15:0] fmt_tag;
        int          pick;
        fmt_tag = pick_format_tag();
        pick = $urandom_range(0, 9);
        if (fmt_tag == FORMAT_EXTENSIBLE)
            len = (pick == 0) ? $urandom_range(16, 39) :
                  (pick == 1) ? $urandom_range(41, 46) : FMT_EXT_MIN_LEN;
        else
            len = (pick == 0) ? $urandom_range(0, 15) :
                  (pick == 1) ? $urandom_range(17, 22) :
                  (pick == 2) ? 32'hFFFF_FFFF : FMT_PLAIN_LEN;
        push_word(TAG_FMT);
        push_word(len);
        if (len < FMT_PLAIN_LEN)
        begin
            push_random($urandom_range(0, 3));
            cut = 1'b1;
        end
        else
        begin
            push_half(fmt_tag);
            push_half(16'($urandom));
            push_word($urandom);
            push_word($urandom);
            push_half(16'($urandom));
            push_half(16'($urandom));
            if (fmt_tag == FORMAT_EXTENSIBLE)
            begin
                if (len < FMT_EXT_MIN_LEN)
                begin
                    push_random($urandom_range(0, 3));
                    cut = 1'b1;
                end
                else
                begin
                    push_random(EXT_GAP_LEN);
                    push_half(pick_format_tag());
                    push_random(((len + 32'd1) & 32'hFFFF_FFFE) - FMT_EXT_USED_LEN);
                end
            end
            else if (len == 32'hFFFF_FFFF)
            begin
                push_random($urandom_range(0, 6));
                cut = 1'b1;
            end
            else if (len > FMT_PLAIN_LEN)
                push_random(((len + 32'd1) & 32'hFFFF_FFFE) - FMT_PLAIN_LEN);
        end
    endtask

    // Builds one file: mostly well-formed headers, some broken, some noise.
    task automatic build_file();
        logic        cut;
        int unsigned keep;
        int unsigned n_other;
        cut = 1'b0;
        file_bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
                push_word(TAG_RIFF);
            push_random($urandom_range(1, 12));
        end
        else
        begin
            push_word(($urandom_range(0, 19) == 0) ? $urandom : TAG_RIFF);
            push_word($urandom);
            push_word(($urandom_range(0, 19) == 0) ? $urandom : TAG_WAVE);
            n_other = $urandom_range(0, 2);
            for (int i = 0; i < n_other && !cut; i++)
                add_other_chunk(cut);
            if (!cut && $urandom_range(0, 9) != 0)
                add_fmt_chunk(cut);
            if (!cut && $urandom_range(0, 3) == 0)
                add_other_chunk(cut);
            if (!cut)
            begin
                push_word(TAG_DATA);
                case ($urandom_range(0, 3))
                    0: push_word(32'd0);
                    1: push_word(32'hFFFF_FFFF);
                    default: push_word($urandom);
                endcase
                push_random($urandom_range(0, 3));
            end
            // Truncate now and then so the file ends mid-header.
            if ($urandom_range(0, 9) == 0)
            begin
                keep = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > keep)
                    void'(file_bytes.pop_back());
            end
        end
    endtask

    // Reset, directed files, random files, then drain.
    initial
    begin
        int wait_cycles;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bad RIFF tag, then bytes after the failure, extreme byte values.
        file_bytes.delete();
        push_word(TAG_RIFF ^ 32'hFF00_0000);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h00);
        send_file();

        // Bad WAVE tag after an all-ones RIFF size.
        file_bytes.delete();
        push_word(TAG_RIFF);
        push_word(32'hFFFF_FFFF);
        push_word(TAG_WAVE ^ 32'h0100_0000);
        file_bytes.push_back(8'h80);
        send_file();

        // A lone start byte clears the failed phase.
        send_byte(8'h52, 1'b1);

        while (board.items_noted < 750)
        begin
            in_steady  = ($urandom_range(0, 3) == 0);
            out_steady = ($urandom_range(0, 3) == 0);
            build_file();
            send_file();
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (board.expected_results.size() != 0 && wait_cycles < 1000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);
        board.report_leftovers();
        if (board.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hard limit on the run time.
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/wavhp_pkg.sv
hw/rtl/wavhp_out_buffer.sv
hw/rtl/wav_header_stream_parser_unit.sv
test/tb_wav_header_stream_parser_unit.sv
